FILE: sv/gsfp_pkg.sv
// ============================================================================
// gsfp_pkg: shared types and constants of the sensor frame parser.
// Frame layout offsets, field lengths, status codes and the stage structs.
// ============================================================================
package gsfp_pkg;

    localparam logic [7:0] SENSOR_TYPE = 8'h91;
    localparam logic [7:0] HDR_BYTES   = 8'd4;
    localparam logic [7:0] MIN_SIZE    = 8'd8;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    // Byte positions within the frame.
    localparam logic [7:0] IDX_SIZE    = 8'd0;
    localparam logic [7:0] IDX_SEQ     = 8'd2;
    localparam logic [7:0] IDX_TYPE    = 8'd3;
    localparam logic [7:0] IDX_MASK_LO = 8'd4;
    localparam logic [7:0] IDX_MASK_HI = 8'd5;
    localparam logic [7:0] IDX_TS      = 8'd6;
    localparam logic [7:0] IDX_SYS     = 8'd7;
    localparam logic [7:0] OPT_BASE    = 8'd8;
    localparam logic [7:0] OPT_END     = 8'd32;

    localparam int OPT_DEPTH = 24;
    localparam int OPT_IDX_W = 5;

    // Optional field lengths in bytes.
    localparam logic [5:0] LEN_DSP   = 6'd2;
    localparam logic [5:0] LEN_GEST  = 6'd4;
    localparam logic [5:0] LEN_TOUCH = 6'd4;
    localparam logic [5:0] LEN_AIR   = 6'd2;
    localparam logic [5:0] LEN_POS   = 6'd6;
    localparam logic [5:0] LEN_NOISE = 6'd4;

    // Data mask bit positions.
    localparam int MB_DSP   = 0;
    localparam int MB_GEST  = 1;
    localparam int MB_TOUCH = 2;
    localparam int MB_AIR   = 3;
    localparam int MB_POS   = 4;
    localparam int MB_NOISE = 5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_SIZE  = 2'd2,
        ST_TYPE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]                  byte_total;
        logic [7:0]                  size_byte;
        logic [7:0]                  type_byte;
        logic [7:0]                  sequence_no;
        logic [15:0]                 opt_mask;
        logic [7:0]                  timestamp;
        logic [7:0]                  sys_byte;
        logic [OPT_DEPTH-1:0][7:0]   opt;
    } t_frame;

    typedef struct packed {
        t_status     status;
        logic [7:0]  sequence_res;
        logic [15:0] opt_mask;
        logic [7:0]  timestamp;
        logic [7:0]  sys_byte;
        logic [15:0] dsp_word;
        logic [31:0] gest_word;
        logic [31:0] touch_word;
        logic [7:0]  airwheel;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
    } t_result;

endpackage

FILE: sv/gesture_sensor_frame_parser_core.sv
// ============================================================================
// gesture_sensor_frame_parser_core: sensor data frame parser, one byte a cycle
// while input ready is high. The last byte of a frame is registered into the
// snapshot, which is checked and loaded into the output register once that
// register is empty or being drained. Synchronous active-low reset empties both
// stages and restarts the byte counter at frame byte 0.
// ============================================================================
module gesture_sensor_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_sequence_res,
    output logic [15:0] o_opt_mask,
    output logic [7:0]  o_timestamp,
    output logic [7:0]  o_sys_byte,
    output logic [15:0] o_dsp_word,
    output logic [31:0] o_gest_word,
    output logic [31:0] o_touch_word,
    output logic [7:0]  o_airwheel,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [15:0] o_pos_z
);

    // The datapath has two stages. The capture stage writes each accepted
    // word that has a place in the working frame into it and, on the word
    // flagged as last, copies the completed frame into a snapshot register. The
    // snapshot is then checked and decoded by purely combinational logic and the
    // answer is loaded into the output register.
    //
    // Because the snapshot and the output register are separate, the parser
    // keeps taking words of the next frame while a result waits to be taken.
    // Input ready only drops when a snapshot is waiting behind a full output
    // register that is not being drained.

    gsfp_pkg::t_frame   snap;
    gsfp_pkg::t_result  eval_res;
    gsfp_pkg::t_result  r_out;
    logic               r_out_valid;
    logic               snap_valid;
    logic               snap_take;

    // A snapshot moves on whenever the output register is empty or emptying.
    assign snap_take = snap_valid && (!r_out_valid || i_out_ready);

    gsfp_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .i_snap_take  (snap_take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    gsfp_eval u_eval (
        .i_frame  (snap),
        .o_result (eval_res)
    );

    // Output register: the valid flag is control state and is reset; the
    // result payload is only ever read while valid is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_take) begin
            r_out <= eval_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_sequence_res = r_out.sequence_res;
    assign o_opt_mask     = r_out.opt_mask;
    assign o_timestamp    = r_out.timestamp;
    assign o_sys_byte     = r_out.sys_byte;
    assign o_dsp_word     = r_out.dsp_word;
    assign o_gest_word    = r_out.gest_word;
    assign o_touch_word   = r_out.touch_word;
    assign o_airwheel     = r_out.airwheel;
    assign o_pos_x        = r_out.pos_x;
    assign o_pos_y        = r_out.pos_y;
    assign o_pos_z        = r_out.pos_z;

    // Input back-pressure is only ever applied while a result is waiting.
    a_ready_low_needs_full_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid
    ) else $error("input stalled while the output register is empty");

    // Any error status clears every decoded field.
    a_error_clears_fields: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != gsfp_pkg::ST_OK) |->
            (o_opt_mask == 16'd0 && o_sequence_res == 8'd0 &&
             o_gest_word == 32'd0 && o_pos_x == 16'd0)
    ) else $error("error result carries non-zero fields");

    // Fields whose mask bit is clear are reported as zero.
    a_absent_fields_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_opt_mask[gsfp_pkg::MB_POS]) |->
            (o_pos_x == 16'd0 && o_pos_y == 16'd0 && o_pos_z == 16'd0)
    ) else $error("position reported although absent from the mask");

endmodule

FILE: sv/gsfp_capture.sv
// ============================================================================
// gsfp_capture: byte capture for the sensor frame parser.
// Stores each byte that has a frame position in its place and hands a finished frame on.
// ============================================================================
module gsfp_capture (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_last_byte,
    input  logic              i_snap_take,
    output logic              o_snap_valid,
    output gsfp_pkg::t_frame  o_snap
);

    logic [7:0]        r_count;
    gsfp_pkg::t_frame  r_work;
    gsfp_pkg::t_frame  n_work;
    gsfp_pkg::t_frame  r_snap;
    logic              r_snap_valid;
    logic              accept;
    logic [7:0]        rel;

    assign o_in_ready   = !r_snap_valid || i_snap_take;
    assign accept       = i_in_valid && o_in_ready;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;
    assign rel          = r_count - gsfp_pkg::OPT_BASE;

    always_comb begin
        n_work            = r_work;
        n_work.byte_total = r_count;
        if (r_count != gsfp_pkg::COUNT_MAX) begin
            n_work.byte_total = r_count + 8'd1;
            case (r_count)
                gsfp_pkg::IDX_SIZE:    n_work.size_byte         = i_frame_byte;
                gsfp_pkg::IDX_SEQ:     n_work.sequence_no       = i_frame_byte;
                gsfp_pkg::IDX_TYPE:    n_work.type_byte         = i_frame_byte;
                gsfp_pkg::IDX_MASK_LO: n_work.opt_mask[7:0]     = i_frame_byte;
                gsfp_pkg::IDX_MASK_HI: n_work.opt_mask[15:8]    = i_frame_byte;
                gsfp_pkg::IDX_TS:      n_work.timestamp         = i_frame_byte;
                gsfp_pkg::IDX_SYS:     n_work.sys_byte          = i_frame_byte;
                default: begin
                    if (r_count >= gsfp_pkg::OPT_BASE && r_count < gsfp_pkg::OPT_END) begin
                        n_work.opt[rel[gsfp_pkg::OPT_IDX_W-1:0]] = i_frame_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= 8'd0;
            r_snap_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= i_last_byte ? 8'd0 : n_work.byte_total;
            end
            if (accept && i_last_byte) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    // Frame contents need no reset: only bytes received in the current frame
    // are ever read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
        if (accept && i_last_byte) begin
            r_snap <= n_work;
        end
    end

endmodule

FILE: sv/gsfp_eval.sv
// ============================================================================
// gsfp_eval: frame checking and field extraction.
// Checks size, type and field fit, and picks the optional fields in mask order.
// ============================================================================
module gsfp_eval (
    input  gsfp_pkg::t_frame   i_frame,
    output gsfp_pkg::t_result  o_result
);

    function automatic logic [7:0] get_byte(
        input logic [gsfp_pkg::OPT_DEPTH-1:0][7:0] opt,
        input logic [5:0] pos
    );
        logic [5:0] r;
        r = pos - gsfp_pkg::OPT_BASE[5:0];
        if (pos >= gsfp_pkg::OPT_BASE[5:0] && r < 6'(gsfp_pkg::OPT_DEPTH)) begin
            return opt[r[gsfp_pkg::OPT_IDX_W-1:0]];
        end else begin
            return 8'd0;
        end
    endfunction

    function automatic logic fits(
        input logic [5:0] off,
        input logic [5:0] len,
        input logic [7:0] msize
    );
        logic [7:0] sum;
        sum = {2'b00, off} + {2'b00, len};
        return sum <= msize;
    endfunction

    logic [15:0] mask;
    logic [5:0]  off0, off1, off2, off3, off4, off5;
    logic        overrun;

    assign mask = i_frame.opt_mask;
    assign off0 = gsfp_pkg::OPT_BASE[5:0];
    assign off1 = mask[gsfp_pkg::MB_DSP]   ? off0 + gsfp_pkg::LEN_DSP   : off0;
    assign off2 = mask[gsfp_pkg::MB_GEST]  ? off1 + gsfp_pkg::LEN_GEST  : off1;
    assign off3 = mask[gsfp_pkg::MB_TOUCH] ? off2 + gsfp_pkg::LEN_TOUCH : off2;
    assign off4 = mask[gsfp_pkg::MB_AIR]   ? off3 + gsfp_pkg::LEN_AIR   : off3;
    assign off5 = mask[gsfp_pkg::MB_POS]   ? off4 + gsfp_pkg::LEN_POS   : off4;

    always_comb begin
        overrun =
            (mask[gsfp_pkg::MB_DSP]   && !fits(off0, gsfp_pkg::LEN_DSP,   i_frame.size_byte)) ||
            (mask[gsfp_pkg::MB_GEST]  && !fits(off1, gsfp_pkg::LEN_GEST,  i_frame.size_byte)) ||
            (mask[gsfp_pkg::MB_TOUCH] && !fits(off2, gsfp_pkg::LEN_TOUCH, i_frame.size_byte)) ||
            (mask[gsfp_pkg::MB_AIR]   && !fits(off3, gsfp_pkg::LEN_AIR,   i_frame.size_byte)) ||
            (mask[gsfp_pkg::MB_POS]   && !fits(off4, gsfp_pkg::LEN_POS,   i_frame.size_byte)) ||
            (mask[gsfp_pkg::MB_NOISE] && !fits(off5, gsfp_pkg::LEN_NOISE, i_frame.size_byte));

        o_result = '0;
        if (i_frame.byte_total < gsfp_pkg::HDR_BYTES) begin
            o_result.status = gsfp_pkg::ST_SHORT;
        end else if (i_frame.size_byte < gsfp_pkg::MIN_SIZE ||
                     i_frame.size_byte > i_frame.byte_total) begin
            o_result.status = gsfp_pkg::ST_SIZE;
        end else if (i_frame.type_byte != gsfp_pkg::SENSOR_TYPE) begin
            o_result.status = gsfp_pkg::ST_TYPE;
        end else if (overrun) begin
            o_result.status = gsfp_pkg::ST_SIZE;
        end else begin
            o_result.status       = gsfp_pkg::ST_OK;
            o_result.sequence_res = i_frame.sequence_no;
            o_result.opt_mask     = mask;
            o_result.timestamp    = i_frame.timestamp;
            o_result.sys_byte     = i_frame.sys_byte;
            if (mask[gsfp_pkg::MB_DSP]) begin
                o_result.dsp_word = {get_byte(i_frame.opt, off0 + 6'd1),
                                     get_byte(i_frame.opt, off0)};
            end
            if (mask[gsfp_pkg::MB_GEST]) begin
                o_result.gest_word = {get_byte(i_frame.opt, off1 + 6'd3),
                                      get_byte(i_frame.opt, off1 + 6'd2),
                                      get_byte(i_frame.opt, off1 + 6'd1),
                                      get_byte(i_frame.opt, off1)};
            end
            if (mask[gsfp_pkg::MB_TOUCH]) begin
                o_result.touch_word = {get_byte(i_frame.opt, off2 + 6'd3),
                                       get_byte(i_frame.opt, off2 + 6'd2),
                                       get_byte(i_frame.opt, off2 + 6'd1),
                                       get_byte(i_frame.opt, off2)};
            end
            if (mask[gsfp_pkg::MB_AIR]) begin
                o_result.airwheel = get_byte(i_frame.opt, off3);
            end
            if (mask[gsfp_pkg::MB_POS]) begin
                o_result.pos_x = {get_byte(i_frame.opt, off4 + 6'd1),
                                  get_byte(i_frame.opt, off4)};
                o_result.pos_y = {get_byte(i_frame.opt, off4 + 6'd3),
                                  get_byte(i_frame.opt, off4 + 6'd2)};
                o_result.pos_z = {get_byte(i_frame.opt, off4 + 6'd5),
                                  get_byte(i_frame.opt, off4 + 6'd4)};
            end
        end
    end

endmodule

FILE: sim/tb.sv
// ============================================================================
// tb: self-checking bench for the sensor data frame parser core.
// Frames are sent a word at a time: a short table of hand-made frames first,
// then random frames, most of them well formed. Every report is checked field by
// field against the report due, from the bench's own parser or a table row.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog fires after this many cycles in which no word moves on
    // either side. The long hold-off below sits well inside it.
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 200;
    localparam int TOTAL_BYTES  = 1050;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIRECTED   = 22;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_sequence_res;
    logic [15:0] o_opt_mask;
    logic [7:0]  o_timestamp;
    logic [7:0]  o_sys_byte;
    logic [15:0] o_dsp_word;
    logic [31:0] o_gest_word;
    logic [31:0] o_touch_word;
    logic [7:0]  o_airwheel;
    logic [15:0] o_pos_x;
    logic [15:0] o_pos_y;
    logic [15:0] o_pos_z;

    gesture_sensor_frame_parser_core DUT (.*);

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench copy of the frame parser. It holds the bytes of the frame being
    // received and works out the report when the last word of a frame goes in.
    // ------------------------------------------------------------------------
    logic [7:0]  p_count;
    logic [7:0]  p_size;
    logic [7:0]  p_type;
    logic [7:0]  p_seq;
    logic [15:0] p_mask;
    logic [7:0]  p_ts;
    logic [7:0]  p_sys;
    logic [7:0]  p_opt [gsfp_pkg::OPT_DEPTH];

    gsfp_pkg::t_result due_reports [$];
    int                mismatches = 0;

    function automatic void clear_parser();
        p_count = '0;
        p_size  = '0;
        p_type  = '0;
        p_seq   = '0;
        p_mask  = '0;
        p_ts    = '0;
        p_sys   = '0;
        foreach (p_opt[k]) p_opt[k] = '0;
    endfunction

    // Optional-field byte at a frame position; outside the store it reads as zero.
    function automatic logic [7:0] opt_at(int pos);
        if (pos < int'(gsfp_pkg::OPT_BASE) || pos >= int'(gsfp_pkg::OPT_END)) return 8'h00;
        return p_opt[5'(pos - int'(gsfp_pkg::OPT_BASE))];
    endfunction

    function automatic logic [15:0] le16(int pos);
        return {opt_at(pos + 1), opt_at(pos)};
    endfunction

    function automatic bit field_fits(int off, int len);
        return off + len <= int'(p_size);
    endfunction

    // Takes one frame byte; returns 1 with the report when the byte is the last.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output gsfp_pkg::t_result res);
        int                off;
        gsfp_pkg::t_status st;
        res = '0;
        // The counter saturates, so bytes from index 255 on are dropped.
        if (p_count != gsfp_pkg::COUNT_MAX) begin
            case (p_count)
                gsfp_pkg::IDX_SIZE:    p_size = b;
                gsfp_pkg::IDX_SEQ:     p_seq = b;
                gsfp_pkg::IDX_TYPE:    p_type = b;
                gsfp_pkg::IDX_MASK_LO: p_mask[7:0] = b;
                gsfp_pkg::IDX_MASK_HI: p_mask[15:8] = b;
                gsfp_pkg::IDX_TS:      p_ts = b;
                gsfp_pkg::IDX_SYS:     p_sys = b;
                default: begin
                    if (p_count >= gsfp_pkg::OPT_BASE && p_count < gsfp_pkg::OPT_END)
                        p_opt[5'(p_count - gsfp_pkg::OPT_BASE)] = b;
                end
            endcase
            p_count = p_count + 8'd1;
        end
        if (!last) return 1'b0;

        st = gsfp_pkg::ST_OK;
        if (p_count < gsfp_pkg::HDR_BYTES) begin
            st = gsfp_pkg::ST_SHORT;
        end else if (p_size < gsfp_pkg::MIN_SIZE || p_size > p_count) begin
            st = gsfp_pkg::ST_SIZE;
        end else if (p_type != gsfp_pkg::SENSOR_TYPE) begin
            st = gsfp_pkg::ST_TYPE;
        end else begin
            res.sequence_res = p_seq;
            res.opt_mask     = p_mask;
            res.timestamp    = p_ts;
            res.sys_byte     = p_sys;
            // Optional fields are packed back to back in mask order, and the
            // first one that runs past the message size fails the frame.
            off = int'(gsfp_pkg::OPT_BASE);
            if (p_mask[gsfp_pkg::MB_DSP]) begin
                if (!field_fits(off, int'(gsfp_pkg::LEN_DSP))) st = gsfp_pkg::ST_SIZE;
                res.dsp_word = le16(off);
                off += int'(gsfp_pkg::LEN_DSP);
            end
            if (st == gsfp_pkg::ST_OK && p_mask[gsfp_pkg::MB_GEST]) begin
                if (!field_fits(off, int'(gsfp_pkg::LEN_GEST))) st = gsfp_pkg::ST_SIZE;
                res.gest_word = {le16(off + 2), le16(off)};
                off += int'(gsfp_pkg::LEN_GEST);
            end
            if (st == gsfp_pkg::ST_OK && p_mask[gsfp_pkg::MB_TOUCH]) begin
                if (!field_fits(off, int'(gsfp_pkg::LEN_TOUCH))) st = gsfp_pkg::ST_SIZE;
                res.touch_word = {le16(off + 2), le16(off)};
                off += int'(gsfp_pkg::LEN_TOUCH);
            end
            if (st == gsfp_pkg::ST_OK && p_mask[gsfp_pkg::MB_AIR]) begin
                if (!field_fits(off, int'(gsfp_pkg::LEN_AIR))) st = gsfp_pkg::ST_SIZE;
                res.airwheel = opt_at(off);
                off += int'(gsfp_pkg::LEN_AIR);
            end
            if (st == gsfp_pkg::ST_OK && p_mask[gsfp_pkg::MB_POS]) begin
                if (!field_fits(off, int'(gsfp_pkg::LEN_POS))) st = gsfp_pkg::ST_SIZE;
                res.pos_x = le16(off);
                res.pos_y = le16(off + 2);
                res.pos_z = le16(off + 4);
                off += int'(gsfp_pkg::LEN_POS);
            end
            // Noise power is only checked for fit, never reported.
            if (st == gsfp_pkg::ST_OK && p_mask[gsfp_pkg::MB_NOISE] &&
                !field_fits(off, int'(gsfp_pkg::LEN_NOISE)))
                st = gsfp_pkg::ST_SIZE;
        end
        // Any error clears every field but the status.
        if (st != gsfp_pkg::ST_OK) res = '0;
        res.status = st;
        clear_parser();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Hand-made frames. Where the status is obvious (short frames, bad sizes,
    // wrong type, overruns) it is typed in with all other fields zero; the
    // remaining rows take their report from the bench parser.
    // ------------------------------------------------------------------------
    typedef struct {
        int                len;
        logic [7:0]        size;
        logic [7:0]        ftype;
        logic [15:0]       mask;
        bit                typed;
        gsfp_pkg::t_status status;
    } t_frame_row;

    t_frame_row directed_frames [N_DIRECTED] = '{
        '{1,   8'h08, gsfp_pkg::SENSOR_TYPE, 16'h0000, 1'b1, gsfp_pkg::ST_SHORT}, // one byte
        '{3,   8'h08, gsfp_pkg::SENSOR_TYPE, 16'h0000, 1'b1, gsfp_pkg::ST_SHORT},
        '{4,   8'h08, gsfp_pkg::SENSOR_TYPE, 16'h0000, 1'b1, gsfp_pkg::ST_SIZE},  // size > frame
        '{8,   8'h07, gsfp_pkg::SENSOR_TYPE, 16'h0000, 1'b1, gsfp_pkg::ST_SIZE},  // size < minimum
        '{8,   8'h00, gsfp_pkg::SENSOR_TYPE, 16'h0000, 1'b1, gsfp_pkg::ST_SIZE},
        '{8,   8'hFF, gsfp_pkg::SENSOR_TYPE, 16'h0000, 1'b1, gsfp_pkg::ST_SIZE},
        '{8,   8'h08, 8'h90,                 16'h0000, 1'b1, gsfp_pkg::ST_TYPE},
        '{8,   8'h08, 8'hFF,                 16'h0000, 1'b1, gsfp_pkg::ST_TYPE},
        '{8,   8'h08, gsfp_pkg::SENSOR_TYPE, 16'h0000, 1'b0, gsfp_pkg::ST_OK},    // header only
        '{10,  8'h0A, gsfp_pkg::SENSOR_TYPE, 16'h0001, 1'b0, gsfp_pkg::ST_OK},
        '{8,   8'h08, gsfp_pkg::SENSOR_TYPE, 16'h0001, 1'b1, gsfp_pkg::ST_SIZE},  // DSP overruns
        '{12,  8'h0C, gsfp_pkg::SENSOR_TYPE, 16'h0002, 1'b0, gsfp_pkg::ST_OK},
        '{12,  8'h0C, gsfp_pkg::SENSOR_TYPE, 16'h0004, 1'b0, gsfp_pkg::ST_OK},
        '{10,  8'h0A, gsfp_pkg::SENSOR_TYPE, 16'h0008, 1'b0, gsfp_pkg::ST_OK},
        '{14,  8'h0E, gsfp_pkg::SENSOR_TYPE, 16'h0010, 1'b0, gsfp_pkg::ST_OK},
        '{12,  8'h0C, gsfp_pkg::SENSOR_TYPE, 16'h0020, 1'b0, gsfp_pkg::ST_OK},
        '{11,  8'h0B, gsfp_pkg::SENSOR_TYPE, 16'h0020, 1'b1, gsfp_pkg::ST_SIZE},  // noise overruns
        '{30,  8'h1E, gsfp_pkg::SENSOR_TYPE, 16'h003F, 1'b0, gsfp_pkg::ST_OK},    // exact fit
        '{29,  8'h1D, gsfp_pkg::SENSOR_TYPE, 16'h003F, 1'b1, gsfp_pkg::ST_SIZE},
        '{40,  8'h14, gsfp_pkg::SENSOR_TYPE, 16'h0010, 1'b0, gsfp_pkg::ST_OK},    // past the size
        '{40,  8'h28, gsfp_pkg::SENSOR_TYPE, 16'hFFFF, 1'b0, gsfp_pkg::ST_OK},    // high mask bits
        '{300, 8'hFF, gsfp_pkg::SENSOR_TYPE, 16'hFFC0, 1'b0, gsfp_pkg::ST_OK}     // counter saturates
    };

    bit                use_typed = 1'b0;
    gsfp_pkg::t_result typed_report;
    bit                tx_calm = 1'b0;
    bit                rx_calm = 1'b0;
    bit                hold_req = 1'b0;
    int                sent_bytes = 0;
    int                frame_no = 0;

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Offers one word, holding it steady until it is taken. Inputs change on
    // the falling edge; acceptance is seen on the rising edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int                gap;
        gsfp_pkg::t_result res;
        gap = tx_calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (parse_byte(b, last, res)) begin
            if (use_typed) res = typed_report;
            due_reports.push_back(res);
        end
    endtask

    task automatic send_frame(input int len, input logic [7:0] size,
                              input logic [7:0] ftype, input logic [15:0] mask);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (i)
                gsfp_pkg::IDX_SIZE:    b = size;
                gsfp_pkg::IDX_TYPE:    b = ftype;
                gsfp_pkg::IDX_MASK_LO: b = mask[7:0];
                gsfp_pkg::IDX_MASK_HI: b = mask[15:8];
                default:               b = 8'($urandom);
            endcase
            send_byte(b, i == len - 1);
        end
        sent_bytes += len;
    endtask

    // Most frames are well formed with random content, so the optional
    // fields get exercised; the rest overrun, carry a wrong type, are noise
    // or are very long.
    task automatic send_random_frame();
        int          kind;
        int          need;
        int          size;
        int          len;
        logic [15:0] mask;
        logic [7:0]  ftype;
        mask[5:0]  = 6'($urandom);
        mask[15:6] = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0;
        need = int'(gsfp_pkg::OPT_BASE)
             + (mask[gsfp_pkg::MB_DSP]   ? int'(gsfp_pkg::LEN_DSP)   : 0)
             + (mask[gsfp_pkg::MB_GEST]  ? int'(gsfp_pkg::LEN_GEST)  : 0)
             + (mask[gsfp_pkg::MB_TOUCH] ? int'(gsfp_pkg::LEN_TOUCH) : 0)
             + (mask[gsfp_pkg::MB_AIR]   ? int'(gsfp_pkg::LEN_AIR)   : 0)
             + (mask[gsfp_pkg::MB_POS]   ? int'(gsfp_pkg::LEN_POS)   : 0)
             + (mask[gsfp_pkg::MB_NOISE] ? int'(gsfp_pkg::LEN_NOISE) : 0);
        ftype = gsfp_pkg::SENSOR_TYPE;
        kind  = $urandom_range(0, 99);
        if (kind < 72) begin
            size = need + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
            len  = size + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
        end else if (kind < 84) begin
            size = need - $urandom_range(1, 4);
            if (size < int'(gsfp_pkg::MIN_SIZE)) size = int'(gsfp_pkg::MIN_SIZE);
            len = size;
        end else if (kind < 92) begin
            size  = need;
            len   = size;
            ftype = 8'($urandom);
        end else if (kind < 98) begin
            len  = $urandom_range(1, 12);
            size = $urandom_range(0, 255);
            if ($urandom_range(0, 1) == 1) ftype = 8'($urandom);
        end else begin
            len  = $urandom_range(200, 300);
            size = $urandom_range(int'(gsfp_pkg::MIN_SIZE), 255);
        end
        send_frame(len, 8'(size), ftype, mask);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset once, the hand-made frames, then random frames. The
    // receiver is asked for one long hold-off at the start of the hand-made
    // frames, while the sender keeps offering words so that the core fills up
    // and stalls its input; after the hand-made frames the sender waits until
    // every report has come back.
    // ------------------------------------------------------------------------
    initial begin
        clear_parser();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        hold_req = 1'b1;
        foreach (directed_frames[n]) begin
            use_typed           = directed_frames[n].typed;
            typed_report        = '0;
            typed_report.status = directed_frames[n].status;
            send_frame(directed_frames[n].len, directed_frames[n].size,
                       directed_frames[n].ftype, directed_frames[n].mask);
        end
        use_typed = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);

        while (sent_bytes < TOTAL_BYTES) begin
            frame_no++;
            // Every so often a run of frames goes out back to back.
            if (frame_no % 8 == 0) tx_calm = !tx_calm;
            send_random_frame();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: random stalls, calm stretches, and the one long hold-off
    // counted out here in cycles.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_calm) stall_left = pick_gap();
            end
            if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
        end
    end

    // Every report word taken is matched against the oldest one due.
    always @(posedge i_clk) begin : report_check
        gsfp_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_reports.size() == 0) begin
                report_mismatch("report word arrived with none due");
            end else begin
                want = due_reports.pop_front();
                check_field("status",       o_status,       want.status);
                check_field("sequence_res", o_sequence_res, want.sequence_res);
                check_field("opt_mask",     o_opt_mask,     want.opt_mask);
                check_field("timestamp",    o_timestamp,    want.timestamp);
                check_field("sys_byte",     o_sys_byte,     want.sys_byte);
                check_field("dsp_word",     o_dsp_word,     want.dsp_word);
                check_field("gest_word",    o_gest_word,    want.gest_word);
                check_field("touch_word",   o_touch_word,   want.touch_word);
                check_field("airwheel",     o_airwheel,     want.airwheel);
                check_field("pos_x",        o_pos_x,        want.pos_x);
                check_field("pos_y",        o_pos_y,        want.pos_y);
                check_field("pos_z",        o_pos_z,        want.pos_z);
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on either side.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("ERROR at %0t ns: no word moved for %0d cycles", $realtime,
                     IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
